[design/mgd_pkg.sv]
`default_nettype none
package mgd_pkg;

    localparam int MAX_PROCS_DEF = 1024;
    localparam int CELL_BITS_DEF = 16;
    localparam int PC_W   = 11;
    localparam int RANK_W = 10;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_PROCS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GY    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GZ    = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SHAPE = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAND,
        ST_W_PC,
        ST_W_A,
        ST_W_B,
        ST_W_AB,
        ST_W_L,
        ST_W_R,
        ST_W_Y,
        ST_W_NY,
        ST_W_NZ,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

[design/mgd_div.sv]
`default_nettype none
module mgd_div #(
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo, r_rem, r_dvs;
    logic [DW:0]   shifted, diff;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[design/mgd_mul.sv]
`default_nettype none
module mgd_mul #(
    parameter int WA = 17,
    parameter int WB = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WA-1:0]    i_a,
    input  wire logic [WB-1:0]    i_b,
    output logic                  o_done,
    output logic [WA+WB-1:0]      o_prod
);
    localparam int CW = $clog2(WA + 1);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [WA+WB-1:0] r_p;
    logic [WB-1:0]    r_b;
    logic [WB:0]      sum;

    assign sum = {1'b0, r_p[WA+WB-1:WA]} + (r_p[0] ? {1'b0, r_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WA);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= {{WB{1'b0}}, i_a};
            r_b <= i_b;
        end else if (r_busy) begin
            r_p <= {sum, r_p[WA-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule
`default_nettype wire

[design/mesh_grid_decompose.sv]
// channel   direction  handshake            payload
// input     in         i_valid / i_ready    i_rank
// result    out        o_valid / o_ready    o_grid_cols .. o_status
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one bit-serial divider (DW = max(CELL_BITS, 11) bits wide) and one shift-add
// multiplier (CELL_BITS + 1 by 2*CELL_BITS bits) are shared by the whole search
// reset is synchronous active low and clears control state and the configuration (set to 1) only
// a new rank is taken while a finished result waits in the output register
`default_nettype none
module mesh_grid_decompose #(
    parameter int MAX_PROCS = mgd_pkg::MAX_PROCS_DEF,
    parameter int CELL_BITS = mgd_pkg::CELL_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mgd_pkg::IDX_W-1:0]            i_cfg_idx,
    input  wire logic [((CELL_BITS > 11) ? CELL_BITS : 11)-1:0] i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      i_ready,
    input  wire logic [mgd_pkg::RANK_W-1:0]           i_rank,
    output logic                                      o_valid,
    input  wire logic                                 o_ready,
    output logic [mgd_pkg::PC_W-1:0]                  o_grid_cols,
    output logic [mgd_pkg::PC_W-1:0]                  o_grid_rows,
    output logic [mgd_pkg::RANK_W-1:0]                o_pos_y,
    output logic [mgd_pkg::RANK_W-1:0]                o_pos_z,
    output logic [CELL_BITS-1:0]                      o_local_cells_y,
    output logic [CELL_BITS-1:0]                      o_local_cells_z,
    output logic [mgd_pkg::RANK_W-1:0]                o_low_y_rank,
    output logic [mgd_pkg::RANK_W-1:0]                o_high_y_rank,
    output logic [mgd_pkg::RANK_W-1:0]                o_low_z_rank,
    output logic [mgd_pkg::RANK_W-1:0]                o_high_z_rank,
    output logic [3:0]                                o_neighbour_mask,
    output logic [1:0]                                o_status
);
    localparam int CB  = CELL_BITS;
    localparam int DW  = (CB > 11) ? CB : 11;
    localparam int PW  = mgd_pkg::PC_W;
    localparam int RW  = mgd_pkg::RANK_W;
    localparam int WA  = CB + 1;
    localparam int WB  = 2 * CB;
    localparam int MPW = WA + WB;
    localparam int PMAX = (MAX_PROCS > 2047) ? 2047 : MAX_PROCS;
    localparam logic [PW-1:0] PMAX_V = PMAX[PW-1:0];

    mgd_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_procs;
    logic [CB-1:0] r_gy, r_gz;

    logic [RW-1:0]  r_rank;
    logic [PW-1:0]  r_p, r_r, r_cols, r_rows;
    logic [PW:0]    r_c;
    logic           r_found;
    logic [CB-1:0]  r_a, r_b, r_ba, r_bb;
    logic [WB-1:0]  r_ab, r_bab;
    logic [MPW-1:0] r_l;
    logic [RW-1:0]  r_y, r_z;
    logic [DW-1:0]  r_ny, r_remy, r_nz, r_remz;

    logic           r_o_valid;
    logic [PW-1:0]  r_o_cols, r_o_rows;
    logic [RW-1:0]  r_o_py, r_o_pz, r_o_ly, r_o_hy, r_o_lz, r_o_hz;
    logic [CB-1:0]  r_o_cy, r_o_cz;
    logic [3:0]     r_o_mask;
    logic [1:0]     r_o_stat;

    logic           div_start, div_done;
    logic [DW-1:0]  div_a, div_b, div_q, div_rm;
    logic           mul_start, mul_done;
    logic [WA-1:0]  mul_a;
    logic [WB-1:0]  mul_b;
    logic [MPW-1:0] mul_p;
    logic           accept, out_load;
    logic [PW-1:0]  p_in;

    mgd_div #(.DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_a), .i_divisor(div_b),
        .o_done(div_done), .o_quot(div_q), .o_rem(div_rm)
    );

    mgd_mul #(.WA(WA), .WB(WB)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_p)
    );

    always_comb begin
        p_in = r_procs;
        if (p_in == '0) p_in = PW'(1);
        if (p_in > PMAX_V) p_in = PMAX_V;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_procs <= PW'(1);
            r_gy    <= CB'(1);
            r_gz    <= CB'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mgd_pkg::CFG_PROCS: r_procs <= i_cfg_data[PW-1:0];
                mgd_pkg::CFG_GY:    r_gy    <= i_cfg_data[CB-1:0];
                mgd_pkg::CFG_GZ:    r_gz    <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mgd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_a     = '0;
        div_b     = DW'(1);
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        accept    = 1'b0;
        out_load  = 1'b0;
        i_ready   = (r_state == mgd_pkg::ST_IDLE);
        unique case (r_state)
            mgd_pkg::ST_IDLE: begin
                if (i_valid) n_state = mgd_pkg::ST_CAND;
            end
            mgd_pkg::ST_CAND: begin
                div_start = 1'b1;
                if (r_c > {1'b0, r_p}) begin
                    div_a   = DW'(r_rank);
                    div_b   = DW'(r_cols);
                    n_state = mgd_pkg::ST_W_Y;
                end else begin
                    div_a   = DW'(r_p);
                    div_b   = DW'(r_c[PW-1:0]);
                    n_state = mgd_pkg::ST_W_PC;
                end
            end
            mgd_pkg::ST_W_PC: begin
                if (div_done) begin
                    if (div_rm != '0) begin
                        n_state = mgd_pkg::ST_CAND;
                    end else begin
                        div_start = 1'b1;
                        div_a     = DW'(r_gy);
                        div_b     = DW'(r_c[PW-1:0]);
                        n_state   = mgd_pkg::ST_W_A;
                    end
                end
            end
            mgd_pkg::ST_W_A: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_a     = DW'(r_gz);
                    div_b     = DW'(r_r);
                    n_state   = mgd_pkg::ST_W_B;
                end
            end
            mgd_pkg::ST_W_B: begin
                if (div_done) begin
                    if (r_a == '0 || div_q[CB-1:0] == '0) begin
                        n_state = mgd_pkg::ST_CAND;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = {1'b0, r_a};
                        mul_b     = WB'(div_q[CB-1:0]);
                        n_state   = mgd_pkg::ST_W_AB;
                    end
                end
            end
            mgd_pkg::ST_W_AB: begin
                if (mul_done) begin
                    if (!r_found) begin
                        accept  = 1'b1;
                        n_state = mgd_pkg::ST_CAND;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = {1'b0, r_a} + {1'b0, r_b};
                        mul_b     = r_bab;
                        n_state   = mgd_pkg::ST_W_L;
                    end
                end
            end
            mgd_pkg::ST_W_L: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = {1'b0, r_ba} + {1'b0, r_bb};
                    mul_b     = r_ab;
                    n_state   = mgd_pkg::ST_W_R;
                end
            end
            mgd_pkg::ST_W_R: begin
                if (mul_done) begin
                    accept  = (r_l < mul_p);
                    n_state = mgd_pkg::ST_CAND;
                end
            end
            mgd_pkg::ST_W_Y: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_a     = DW'(r_gy);
                    div_b     = DW'(r_cols);
                    n_state   = mgd_pkg::ST_W_NY;
                end
            end
            mgd_pkg::ST_W_NY: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_a     = DW'(r_gz);
                    div_b     = DW'(r_rows);
                    n_state   = mgd_pkg::ST_W_NZ;
                end
            end
            mgd_pkg::ST_W_NZ: begin
                if (div_done) n_state = mgd_pkg::ST_OUT;
            end
            mgd_pkg::ST_OUT: begin
                if (!r_o_valid || o_ready) begin
                    out_load = 1'b1;
                    n_state  = mgd_pkg::ST_IDLE;
                end
            end
            default: n_state = mgd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (r_state == mgd_pkg::ST_IDLE && i_valid) begin
            r_found <= 1'b0;
        end else if (accept) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mgd_pkg::ST_IDLE && i_valid) begin
            r_rank <= i_rank;
            r_p    <= p_in;
            r_c    <= (PW+1)'(1);
            r_cols <= PW'(1);
            r_rows <= p_in;
        end
        if (r_state != mgd_pkg::ST_IDLE && r_state != mgd_pkg::ST_CAND
                && n_state == mgd_pkg::ST_CAND) begin
            r_c <= r_c + 1'b1;
        end
        if (r_state == mgd_pkg::ST_W_PC && div_done) r_r <= div_q[PW-1:0];
        if (r_state == mgd_pkg::ST_W_A && div_done) r_a <= div_q[CB-1:0];
        if (r_state == mgd_pkg::ST_W_B && div_done) r_b <= div_q[CB-1:0];
        if (r_state == mgd_pkg::ST_W_AB && mul_done) r_ab <= mul_p[WB-1:0];
        if (r_state == mgd_pkg::ST_W_L && mul_done) r_l <= mul_p;
        if (accept) begin
            r_ba   <= r_a;
            r_bb   <= r_b;
            r_bab  <= (r_state == mgd_pkg::ST_W_AB) ? mul_p[WB-1:0] : r_ab;
            r_cols <= r_c[PW-1:0];
            r_rows <= r_r;
        end
        if (r_state == mgd_pkg::ST_W_Y && div_done) begin
            r_y <= div_rm[RW-1:0];
            r_z <= div_q[RW-1:0];
        end
        if (r_state == mgd_pkg::ST_W_NY && div_done) begin
            r_ny   <= div_q;
            r_remy <= div_rm;
        end
        if (r_state == mgd_pkg::ST_W_NZ && div_done) begin
            r_nz   <= div_q;
            r_remz <= div_rm;
        end
    end

    logic          in_range, has_ly, has_hy, has_lz, has_hz;
    logic [CB-1:0] cy, cz;

    always_comb begin
        in_range = ({1'b0, r_rank} < r_p);
        has_ly   = (r_y != '0);
        has_hy   = ({1'b0, r_y} + 1'b1 < r_cols);
        has_lz   = (r_z != '0);
        has_hz   = ({1'b0, r_z} + 1'b1 < r_rows);
        cy       = r_ny[CB-1:0] + CB'(DW'(r_y) < r_remy);
        cz       = r_nz[CB-1:0] + CB'(DW'(r_z) < r_remz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_cols <= r_cols;
            r_o_rows <= r_rows;
            if (in_range) begin
                r_o_py   <= r_y;
                r_o_pz   <= r_z;
                r_o_cy   <= cy;
                r_o_cz   <= cz;
                r_o_ly   <= has_ly ? r_rank - 1'b1 : '0;
                r_o_hy   <= has_hy ? r_rank + 1'b1 : '0;
                r_o_lz   <= has_lz ? r_rank - r_cols[RW-1:0] : '0;
                r_o_hz   <= has_hz ? r_rank + r_cols[RW-1:0] : '0;
                r_o_mask <= {has_hz, has_lz, has_hy, has_ly};
                r_o_stat <= r_found ? mgd_pkg::STAT_OK : mgd_pkg::STAT_NO_SHAPE;
            end else begin
                r_o_py   <= '0;
                r_o_pz   <= '0;
                r_o_cy   <= '0;
                r_o_cz   <= '0;
                r_o_ly   <= '0;
                r_o_hy   <= '0;
                r_o_lz   <= '0;
                r_o_hz   <= '0;
                r_o_mask <= '0;
                r_o_stat <= mgd_pkg::STAT_RANGE;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_grid_cols      = r_o_cols;
    assign o_grid_rows      = r_o_rows;
    assign o_pos_y          = r_o_py;
    assign o_pos_z          = r_o_pz;
    assign o_local_cells_y  = r_o_cy;
    assign o_local_cells_z  = r_o_cz;
    assign o_low_y_rank     = r_o_ly;
    assign o_high_y_rank    = r_o_hy;
    assign o_low_z_rank     = r_o_lz;
    assign o_high_z_rank    = r_o_hz;
    assign o_neighbour_mask = r_o_mask;
    assign o_status         = r_o_stat;

`ifndef SYNTHESIS
    a_range_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mgd_pkg::STAT_RANGE) |->
        (o_neighbour_mask == '0 && o_pos_y == '0 && o_pos_z == '0))
        else $error("out of range result carries placement");
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != mgd_pkg::STAT_RANGE) |->
        ({1'b0, o_pos_y} < o_grid_cols && {1'b0, o_pos_z} < o_grid_rows))
        else $error("position outside grid");
    a_grid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_grid_cols != '0 && o_grid_rows != '0))
        else $error("empty grid dimension");
`endif
endmodule
`default_nettype wire
